// File: rtl/core/sowi_pkg.sv
package sowi_pkg;

    // Default sizing of the word table
    localparam int MAX_WORDS_DEF   = 1024;
    localparam int OFFSET_BITS_DEF = 32;

    // Fixed field widths of the words on the channels
    localparam int CMD_W    = 2;
    localparam int OFS_W    = 32;
    localparam int TYPE_W   = 16;
    localparam int RESULT_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SPAN   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST_GO,
        ST_FIRST_RUN,
        ST_COUNT_GO,
        ST_COUNT_RUN,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/core/sowi_if.sv
interface sowi_item_if
    import sowi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [OFS_W-1:0]  word_offset;
    logic [TYPE_W-1:0] span_type;
    logic [OFS_W-1:0]  span_begin;
    logic [OFS_W-1:0]  span_length;

    modport source (
        output valid, cmd, word_offset, span_type, span_begin, span_length,
        input  ready
    );
    modport sink (
        input  valid, cmd, word_offset, span_type, span_begin, span_length,
        output ready
    );
endinterface

interface sowi_result_if
    import sowi_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   out_type;
    logic [RESULT_W-1:0] first_word;
    logic [RESULT_W-1:0] words_in_span;

    modport source (
        output valid, out_type, first_word, words_in_span,
        input  ready
    );
    modport sink (
        input  valid, out_type, first_word, words_in_span,
        output ready
    );
endinterface

interface sowi_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: rtl/core/sowi_cell.sv
// One bisection step: hold a half-open range, narrow it with the probed entry.
module sowi_cell
    import sowi_pkg::*;
#(
    parameter int CNT_W       = 11,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   feed_valid,
    input  logic [CNT_W-1:0]       feed_lo,
    input  logic [CNT_W-1:0]       feed_hi,
    input  logic [OFFSET_BITS-1:0] rdata,
    input  logic [OFFSET_BITS:0]   key,
    output logic                   pass_valid,
    output logic [CNT_W-1:0]       pass_lo,
    output logic [CNT_W-1:0]       pass_hi,
    output logic [CNT_W-1:0]       pass_mid
);

    logic             valid_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W:0]   cur_sum;
    logic [CNT_W-1:0] cur_mid;
    logic [CNT_W:0]   pass_sum;
    logic             below;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= feed_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= feed_lo;
        hi_reg <= feed_hi;
    end

    always_comb
    begin
        cur_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        cur_mid = cur_sum[CNT_W:1];
        below   = {1'b0, rdata} < key;
        pass_lo = lo_reg;
        pass_hi = hi_reg;
        if (lo_reg < hi_reg)
        begin
            if (below)
            begin
                pass_lo = cur_mid + 1'b1;
            end
            else
            begin
                pass_hi = cur_mid;
            end
        end
        pass_sum   = {1'b0, pass_lo} + {1'b0, pass_hi};
        pass_mid   = pass_sum[CNT_W:1];
        pass_valid = valid_reg;
    end

endmodule

// File: rtl/core/sowi_search.sv
// Word table memory and the row of bisection cells that probe it.
module sowi_search
    import sowi_pkg::*;
#(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_WORDS + 1),
    parameter int ADDR_W      = $clog2(MAX_WORDS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [OFFSET_BITS-1:0] wr_data,
    input  logic                   start,
    input  logic [CNT_W-1:0]       lo,
    input  logic [CNT_W-1:0]       hi,
    input  logic [OFFSET_BITS:0]   key,
    output logic                   done,
    output logic [CNT_W-1:0]       found
);

    localparam int STEPS = CNT_W;

    logic [OFFSET_BITS-1:0] mem [MAX_WORDS];
    logic [OFFSET_BITS-1:0] rdata_reg;
    logic [ADDR_W-1:0]      rd_addr;

    logic             link_valid [STEPS+1];
    logic [CNT_W-1:0] link_lo    [STEPS+1];
    logic [CNT_W-1:0] link_hi    [STEPS+1];
    logic [CNT_W-1:0] link_mid   [STEPS+1];
    logic [CNT_W:0]   start_sum;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        start_sum     = {1'b0, lo} + {1'b0, hi};
        link_valid[0] = start;
        link_lo[0]    = lo;
        link_hi[0]    = hi;
        link_mid[0]   = start_sum[CNT_W:1];
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        sowi_cell #(
            .CNT_W       (CNT_W),
            .OFFSET_BITS (OFFSET_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .feed_valid (link_valid[k]),
            .feed_lo    (link_lo[k]),
            .feed_hi    (link_hi[k]),
            .rdata      (rdata_reg),
            .key        (key),
            .pass_valid (link_valid[k+1]),
            .pass_lo    (link_lo[k+1]),
            .pass_hi    (link_hi[k+1]),
            .pass_mid   (link_mid[k+1])
        );
    end

    // Only one link carries a range at a time: probe at its midpoint
    always_comb
    begin
        rd_addr = '0;
        for (int k = 0; k <= STEPS; k++)
        begin
            if (link_valid[k])
            begin
                rd_addr = rd_addr | link_mid[k][ADDR_W-1:0];
            end
        end
    end

    assign done  = link_valid[STEPS];
    assign found = link_lo[STEPS];

endmodule

// File: rtl/core/span_offset_to_word_index.sv
// Clear and append words are taken whenever the block is idle; a span holds off
// the input while two bisections run through the S-cell chain, S = clog2(MAX_WORDS+1),
// one probe a cycle on the table's single read port.
// A span result appears in the same cycle that the next word can be taken; it may wait.
// Reset (rst_n low, asynchronous) empties the table and clears allow_empty;
// table contents stay undefined until written.
module span_offset_to_word_index
    import sowi_pkg::*;
#(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sowi_item_if.sink     item,
    sowi_result_if.source result,
    sowi_cfg_if.sink      cfg
);

    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W = $clog2(MAX_WORDS);
    localparam int KEY_W  = OFFSET_BITS + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    words_reg, words_next;
    logic                allow_reg;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    end_reg, end_next;
    logic [CNT_W-1:0]    first_reg, first_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]   out_type_reg, out_type_next;
    logic [RESULT_W-1:0] out_first_reg, out_first_next;
    logic [RESULT_W-1:0] out_count_reg, out_count_next;

    logic                   accept;
    logic [OFFSET_BITS-1:0] append_ofs;
    logic [OFFSET_BITS-1:0] begin_ofs;
    logic [OFFSET_BITS-1:0] length_ofs;
    logic [KEY_W-1:0]       span_end;
    logic [CNT_W-1:0]       span_count;
    logic                   emit_load;

    logic                   wr_en;
    logic                   start;
    logic [CNT_W-1:0]       search_lo;
    logic                   done;
    logic [CNT_W-1:0]       found;

    // Word table and bisection chain
    sowi_search #(
        .MAX_WORDS   (MAX_WORDS),
        .OFFSET_BITS (OFFSET_BITS),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (words_reg[ADDR_W-1:0]),
        .wr_data (append_ofs),
        .start   (start),
        .lo      (search_lo),
        .hi      (words_reg),
        .key     (key_reg),
        .done    (done),
        .found   (found)
    );

    assign accept     = item.valid && item.ready;
    assign append_ofs = OFFSET_BITS'(item.word_offset);
    assign begin_ofs  = OFFSET_BITS'(item.span_begin);
    assign length_ofs = OFFSET_BITS'(item.span_length);
    assign span_count = found - first_reg;

    // Span end never wraps; at full 64-bit offsets it clamps to all ones
    always_comb
    begin
        span_end = {1'b0, begin_ofs} + {1'b0, length_ofs};
        if (OFFSET_BITS >= 64 && span_end[KEY_W-1])
        begin
            span_end = {1'b0, {OFFSET_BITS{1'b1}}};
        end
    end

    // Configuration is taken at any time; the host writes it only while idle
    assign cfg.ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.cmd == CMD_SPAN)
                begin
                    state_next = ST_FIRST_GO;
                end
            end
            ST_FIRST_GO:
            begin
                state_next = ST_FIRST_RUN;
            end
            ST_FIRST_RUN:
            begin
                if (done)
                begin
                    if (found < words_reg)
                    begin
                        state_next = ST_COUNT_GO;
                    end
                    else if (allow_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_COUNT_GO:
            begin
                state_next = ST_COUNT_RUN;
            end
            ST_COUNT_RUN:
            begin
                if (done)
                begin
                    if (span_count == '0 && !allow_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        item.ready     = (state_reg == ST_IDLE);
        start          = (state_reg == ST_FIRST_GO) || (state_reg == ST_COUNT_GO);
        search_lo      = (state_reg == ST_COUNT_GO) ? first_reg : '0;
        emit_load      = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
        wr_en          = 1'b0;
        words_next     = words_reg;
        type_next      = type_reg;
        key_next       = key_reg;
        end_next       = end_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_type_next  = out_type_reg;
        out_first_next = out_first_reg;
        out_count_next = out_count_reg;

        if (accept)
        begin
            unique case (item.cmd)
                CMD_CLEAR:
                begin
                    words_next = '0;
                end
                CMD_APPEND:
                begin
                    // Drop appends once the table is full
                    if (words_reg < CNT_W'(MAX_WORDS))
                    begin
                        wr_en      = 1'b1;
                        words_next = words_reg + 1'b1;
                    end
                end
                CMD_SPAN:
                begin
                    type_next = item.span_type;
                    key_next  = {1'b0, begin_ofs};
                    end_next  = span_end;
                end
                default:
                begin
                    // Unused command: ignore the word
                end
            endcase
        end

        if (state_reg == ST_FIRST_RUN && done)
        begin
            first_next = found;
            count_next = '0;
            key_next   = end_reg;
        end

        if (state_reg == ST_COUNT_RUN && done)
        begin
            count_next = span_count;
        end

        if (emit_load)
        begin
            out_valid_next = 1'b1;
            out_type_next  = type_reg;
            out_first_next = RESULT_W'(first_reg);
            out_count_next = RESULT_W'(count_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            words_reg     <= '0;
            allow_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                allow_reg <= cfg.data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        key_reg       <= key_next;
        end_reg       <= end_next;
        first_reg     <= first_next;
        count_reg     <= count_next;
        out_type_reg  <= out_type_next;
        out_first_reg <= out_first_next;
        out_count_reg <= out_count_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.out_type      = out_type_reg;
    assign result.first_word    = out_first_reg;
    assign result.words_in_span = out_count_reg;

endmodule

// File: tb/tb_span_offset_to_word_index.sv
module tb_span_offset_to_word_index
    import sowi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_WORDS     = MAX_WORDS_DEF;
    localparam int ITEM_TARGET     = 1600;
    // Margin for a span conversion still in flight after a drain.
    localparam int SETTLE_CYCLES   = 40;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_GAP         = 11;

    // Command code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [OFS_W-1:0]  word_offset;
        logic [TYPE_W-1:0] span_type;
        logic [OFS_W-1:0]  span_begin;
        logic [OFS_W-1:0]  span_length;
    } span_word_t;

    typedef struct packed {
        logic [TYPE_W-1:0]   out_type;
        logic [RESULT_W-1:0] first_word;
        logic [RESULT_W-1:0] words_in_span;
    } span_result_t;

    // Scoreboard: a private copy of the offset table and the allow_empty
    // flag, plus the queue of span conversions still to come out.
    class span_scoreboard;
        logic [OFS_W-1:0] word_starts_q [TABLE_WORDS];
        int unsigned      words_loaded_q;
        bit               allow_empty_q;
        span_result_t     pending_q [$];
        int unsigned      errors;

        function new();
            words_loaded_q = 0;
            allow_empty_q  = 1'b0;
            errors         = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Plain lower-bound bisection over [lo, hi); exact for sorted tables.
        function int unsigned seek_at_or_above(int unsigned lo, int unsigned hi,
                                               longint unsigned key);
            int unsigned mid;
            while (lo < hi)
            begin
                mid = lo + ((hi - lo) >> 1);
                if (longint'({32'h0, word_starts_q[mid % TABLE_WORDS]}) < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void note_word(span_word_t w);
            longint unsigned span_start;
            longint unsigned span_stop;
            int unsigned     first;
            int unsigned     count;
            span_result_t    res;
            case (w.cmd)
                CMD_CLEAR:
                    words_loaded_q = 0;
                CMD_APPEND:
                    if (words_loaded_q < TABLE_WORDS)
                    begin
                        word_starts_q[words_loaded_q] = w.word_offset;
                        words_loaded_q++;
                    end
                CMD_SPAN:
                begin
                    span_start = {32'h0, w.span_begin};
                    // 32-bit begin and length never overflow 64 bits
                    span_stop  = span_start + {32'h0, w.span_length};
                    first = seek_at_or_above(0, words_loaded_q, span_start);
                    if (first >= words_loaded_q)
                    begin
                        if (!allow_empty_q)
                            return;
                        first = words_loaded_q;
                        count = 0;
                    end
                    else
                    begin
                        count = seek_at_or_above(first, words_loaded_q, span_stop) - first;
                        if (count == 0 && !allow_empty_q)
                            return;
                    end
                    res.out_type      = w.span_type;
                    res.first_word    = first[RESULT_W-1:0];
                    res.words_in_span = count[RESULT_W-1:0];
                    pending_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        task check_result(span_result_t got);
            span_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result type=%h first=%0d count=%0d",
                                          got.out_type, got.first_word, got.words_in_span));
                return;
            end
            want = pending_q.pop_front();
            if (got.out_type !== want.out_type)
                report_mismatch($sformatf("out_type %h, want %h", got.out_type, want.out_type));
            if (got.first_word !== want.first_word)
                report_mismatch($sformatf("first_word %0d, want %0d",
                                          got.first_word, want.first_word));
            if (got.words_in_span !== want.words_in_span)
                report_mismatch($sformatf("words_in_span %0d, want %0d",
                                          got.words_in_span, want.words_in_span));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sowi_item_if   item_ch ();
    sowi_result_if result_ch ();
    sowi_cfg_if    cfg_ch ();

    span_scoreboard sb = new();

    // Offsets appended since the last clear, as the stimulus sees them;
    // used to aim span boundaries at, just below and just above entries.
    logic [OFS_W-1:0] loaded_offsets [$];
    int unsigned      words_sent;
    bit               tx_burst;
    bit               rx_burst;
    int unsigned      hold_off_req;

    span_offset_to_word_index #(
        .MAX_WORDS   (TABLE_WORDS),
        .OFFSET_BITS (OFFSET_BITS_DEF)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic span_word_t make_word(logic [CMD_W-1:0] cmd, logic [OFS_W-1:0] ofs,
                                             logic [OFS_W-1:0] kind, logic [OFS_W-1:0] b,
                                             logic [OFS_W-1:0] len);
        span_word_t w;
        w.cmd         = cmd;
        w.word_offset = ofs;
        w.span_type   = kind[TYPE_W-1:0];
        w.span_begin  = b;
        w.span_length = len;
        return w;
    endfunction

    // Offer one word: idle for a random gap (none in burst mode), then
    // hold valid until the block takes it. Called just after a rising edge.
    task automatic send_word(span_word_t w);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= w.cmd;
        item_ch.word_offset <= w.word_offset;
        item_ch.span_type   <= w.span_type;
        item_ch.span_begin  <= w.span_begin;
        item_ch.span_length <= w.span_length;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_word(w);
        case (w.cmd)
            CMD_CLEAR:  loaded_offsets.delete();
            CMD_APPEND: if (loaded_offsets.size() < TABLE_WORDS)
                            loaded_offsets.push_back(w.word_offset);
            default: ;
        endcase
        if (w.cmd != CMD_RESERVED)
            words_sent++;
    endtask

    task automatic send_noise();
        send_word(make_word(CMD_RESERVED, $urandom, $urandom, $urandom, $urandom));
    endtask

    // Send one span, mostly with edges aimed at loaded offsets, sometimes
    // at the extremes or anywhere at all.
    task automatic send_probe();
        logic [OFS_W-1:0] b;
        logic [OFS_W-1:0] len;
        int unsigned      n;
        n = loaded_offsets.size();
        case ($urandom_range(0, 7))
            0: b = '0;
            1: b = '1;
            2: b = $urandom;
            default:
                if (n == 0)
                    b = $urandom_range(0, 100);
                else
                    b = loaded_offsets[$urandom_range(0, n - 1)] - 1 + $urandom_range(0, 2);
        endcase
        case ($urandom_range(0, 7))
            0: len = '0;
            1: len = '1;
            2: len = $urandom;
            3: len = $urandom_range(1, 8);
            default:
                if (n == 0)
                    len = $urandom_range(0, 1000);
                else
                    len = loaded_offsets[$urandom_range(0, n - 1)] - b - 1
                          + $urandom_range(0, 2);
        endcase
        send_word(make_word(CMD_SPAN, $urandom, $urandom, b, len));
    endtask

    // Clear the table and append n offsets: ascending with random steps up to
    // max_step (0 picks one), or arbitrary when in_order is low. Mix in
    // the odd span and ignored command while the table grows.
    task automatic load_table(int unsigned n, bit in_order, int unsigned max_step);
        longint unsigned  cursor;
        logic [OFS_W-1:0] ofs;
        int unsigned      i;
        if (max_step == 0)
            case ($urandom_range(0, 4))
                0: max_step = 1;
                1: max_step = 3;
                2: max_step = 64;
                3: max_step = 65536;
                default: max_step = 1 << 26;
            endcase
        tx_burst = ($urandom_range(0, 3) == 0);
        send_word(make_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
        case ($urandom_range(0, 2))
            0: cursor = 0;
            1: cursor = longint'($urandom_range(0, 1000));
            default:
                if (longint'(n) * max_step > 64'hFFFF_FFFF)
                    cursor = 0;
                else
                    cursor = 64'hFFFF_FFFF - longint'(n) * max_step;
        endcase
        for (i = 0; i < n; i++)
        begin
            if (in_order)
            begin
                // now and then repeat an offset instead of stepping past it
                if (i > 0 && $urandom_range(0, 19) != 0)
                    cursor += longint'($urandom_range(1, max_step));
                if (cursor > 64'hFFFF_FFFF)
                    break;
                ofs = cursor[OFS_W-1:0];
            end
            else
                ofs = $urandom;
            send_word(make_word(CMD_APPEND, ofs, $urandom, $urandom, $urandom));
            case ($urandom_range(0, 29))
                0, 1: send_probe();
                2:    send_noise();
                default: ;
            endcase
        end
    endtask

    task automatic probe_table(int unsigned n);
        repeat (n)
            send_probe();
    endtask

    // Drop valid, wait for every outstanding result, then let a dropped span
    // still in flight finish before anything else happens.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        item_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending_q.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d expected results never came",
                                         sb.pending_q.size()));
            sb.pending_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_allow_empty(bit value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.allow_empty_q = value;
    endtask

    // Main stimulus
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned phase_start;

        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.cmd           <= CMD_CLEAR;
        item_ch.word_offset   <= '0;
        item_ch.span_type     <= '0;
        item_ch.span_begin    <= '0;
        item_ch.span_length   <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.data           <= 1'b0;
        words_sent   = 0;
        tx_burst     = 1'b0;
        hold_off_req = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        drain();
        write_allow_empty(1'b0);

        // Empty spans dropped: empty table and zero-word spans, amid spans that are kept.
        send_word(make_word(CMD_SPAN, $urandom, 32'h0000_0000, 32'h0, 32'h0));
        send_noise();
        send_word(make_word(CMD_APPEND, 32'h0, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_APPEND, 32'd10, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_APPEND, 32'd20, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_APPEND, 32'hFFFF_FFFF, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_SPAN, $urandom, 32'h0000_FFFF, 32'h0, 32'h0));
        // all but the last entry, then an end beyond 32 bits
        send_word(make_word(CMD_SPAN, $urandom, 32'h0000_1234, 32'h0, 32'hFFFF_FFFF));
        send_word(make_word(CMD_SPAN, $urandom, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'd5, 32'd10));
        send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'd21, 32'd1));

        drain();
        write_allow_empty(1'b1);

        // Same zero-word span now kept; empty table kept as (0, 0).
        send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'd21, 32'd1));
        send_word(make_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_SPAN, $urandom, $urandom, $urandom, $urandom));
        // offsets out of order: bisection result, not a true lower bound
        send_word(make_word(CMD_APPEND, 32'd30, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_APPEND, 32'd10, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_APPEND, 32'd20, $urandom, $urandom, $urandom));
        send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'd15, 32'd10));
        send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'hFFFF_FFFF, 32'h0));
        send_noise();

        // Random phases; allow_empty changes only between them.
        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            drain();
            if (phase == 0)
                write_allow_empty(1'b0);
            else if (phase == 1)
                write_allow_empty(1'b1);
            else
                write_allow_empty(1'($urandom_range(0, 1)));
            if (phase == 1)
            begin
                // Overfill the table, then stall the result side while spans
                // keep coming so the block backs up into its input.
                load_table(TABLE_WORDS + 6, 1'b1, 8);
                hold_off_req++;
                send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'h0, 32'hFFFF_FFFF));
                send_word(make_word(CMD_SPAN, $urandom, $urandom, 32'hFFFF_FFFF, $urandom));
                probe_table(30);
            end
            else
            begin
                phase_start = words_sent;
                while (words_sent - phase_start < 120 && words_sent < ITEM_TARGET)
                begin
                    load_table(($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                           : $urandom_range(0, 12),
                               ($urandom_range(0, 4) != 0), 0);
                    probe_table($urandom_range(2, 10));
                    if ($urandom_range(0, 3) == 0)
                        send_noise();
                end
            end
            phase++;
        end

        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall before each word, runs of no stall, and one
    // long hold-off when the stimulus asks for it.
    initial
    begin : result_sink
        int unsigned  stall;
        int unsigned  hold_off_done;
        span_result_t got;

        result_ch.ready <= 1'b0;
        rx_burst      = 1'b0;
        hold_off_done = 0;

        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req != hold_off_done)
            begin
                hold_off_done = hold_off_req;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got.out_type      = result_ch.out_type;
            got.first_word    = result_ch.first_word;
            got.words_in_span = result_ch.words_in_span;
            sb.check_result(got);
        end
    end

    // Watchdog
    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
